/* rtl/tps_pkg.sv */
// Package: item types, event codes and constants of the timer pool scheduler.
`timescale 1ns / 1ps

package tps_pkg;

    // Input functions
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_CREATE = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    // Result kinds
    localparam logic [2:0] K_CREATED = 3'd0;
    localparam logic [2:0] K_FULL    = 3'd1;
    localparam logic [2:0] K_FIRE    = 3'd2;
    localparam logic [2:0] K_ENDED   = 3'd3;
    localparam logic [2:0] K_REMOVED = 3'd4;
    localparam logic [2:0] K_REFUSED = 3'd5;

    // Results reported per input item at most
    localparam int MAX_RESULTS = 16;
    // Width of a slot select on the command bus (pool of up to 256)
    localparam int SEL_W = 8;

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] wait_ticks;
        logic [23:0] run_ticks;
        logic [23:0] period_ticks;
        logic        has_action;
        logic        has_end;
        logic [3:0]  slot;
        logic        notify_end;
    } t_in;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] slot_res;
        logic       end_notice;
        logic       last;
    } t_out;

    // Command broadcast from the controller to all cells
    typedef struct packed {
        logic             cre;
        logic             rem;
        logic [SEL_W-1:0] sel;
        logic [23:0]      wait_len;
        logic [23:0]      run_len;
        logic [23:0]      period_len;
        logic [1:0]       flags;
    } t_cmd;

    // Event raised by the cell holding the scan token
    typedef struct packed {
        logic fire;
        logic ended;
    } t_cev;

endpackage

/* rtl/tps_cell.sv */
// One timer slot: its state, its tick update and the scan token stage.
`timescale 1ns / 1ps

module tps_cell
    import tps_pkg::*;
#(
    parameter int ID        = 0,
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_tok,
    input  logic                 i_adv,
    input  logic [TIME_BITS-1:0] i_now,
    input  t_cmd                 i_cmd,
    output logic                 o_tok,
    output t_cev                 o_ev,
    output logic                 o_used,
    output logic                 o_end_flag
);

    localparam int CMPW = (TIME_BITS > 24) ? TIME_BITS : 24;

    localparam logic [1:0] PH_ARM  = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;

    logic                 r_tok;
    logic                 r_used;
    logic [1:0]           r_phase;
    logic [TIME_BITS-1:0] r_mark;
    logic [TIME_BITS-1:0] r_last;
    logic [23:0]          r_wait;
    logic [23:0]          r_run;
    logic [23:0]          r_period;
    logic [1:0]           r_flags;

    logic [TIME_BITS-1:0] d_mark;
    logic [TIME_BITS-1:0] d_last;
    logic [CMPW-1:0]      since_mark;
    logic [CMPW-1:0]      since_last;
    logic                 hit;
    logic                 active;
    logic                 wait_done;
    logic                 in_run;
    logic                 period_due;

    // Time differences wrap at the counter width
    assign d_mark     = i_now - r_mark;
    assign d_last     = i_now - r_last;
    assign since_mark = CMPW'(d_mark);
    assign since_last = CMPW'(d_last);
    assign hit        = (i_cmd.sel == SEL_W'(ID));
    assign active     = r_tok && r_used;

    assign wait_done  = (r_wait == 24'd0) || (since_mark >= CMPW'(r_wait));
    assign in_run     = (r_run == 24'd0) || (since_mark <= CMPW'(r_run));
    assign period_due = (r_period == 24'd0) || (since_last >= CMPW'(r_period));

    // Events of this slot while it holds the token
    always_comb begin
        o_ev.fire  = active && (r_phase == PH_RUN) && in_run && r_flags[0] && period_due;
        o_ev.ended = active && (r_phase == PH_RUN) && !in_run && r_flags[1];
    end

    assign o_tok      = r_tok;
    assign o_used     = r_used;
    assign o_end_flag = r_flags[1];

    // Scan token stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_load) begin
            r_tok <= i_tok;
        end
    end

    // Slot state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_phase <= PH_ARM;
        end else if (i_cmd.cre && hit) begin
            r_used   <= 1'b1;
            r_phase  <= PH_ARM;
            r_wait   <= i_cmd.wait_len;
            r_run    <= i_cmd.run_len;
            r_period <= i_cmd.period_len;
            r_flags  <= i_cmd.flags;
        end else if (i_cmd.rem && hit) begin
            r_used  <= 1'b0;
            r_phase <= PH_ARM;
        end else if (active && i_adv) begin
            case (r_phase)
                PH_ARM: begin
                    r_mark  <= i_now;
                    r_phase <= PH_WAIT;
                end
                PH_WAIT: begin
                    if (wait_done) begin
                        r_phase <= PH_RUN;
                        r_mark  <= i_now;
                        r_last  <= i_now;
                    end
                end
                default: begin
                    if (in_run) begin
                        if (r_flags[0] && r_period != 24'd0 && period_due) begin
                            r_last <= i_now;
                        end
                    end else if (r_flags[1]) begin
                        r_used  <= 1'b0;
                        r_phase <= PH_ARM;
                    end
                end
            endcase
        end
    end

endmodule

/* rtl/timer_pool_scheduler.sv */
// Top level: controller, free slot stack and the chain of timer cells.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------
//  input    | i_valid / o_stall   | i_item (t_in)
//  output   | o_valid / i_stall   | o_item (t_out)
//
// During a tick the token visits one cell per cycle unless the scan is held.
// A create passes through the free stack read, the update and the flush; a remove
// goes from acceptance straight to the flush. After reset the free stack is
// filled before the first item is taken. A stalled output holds the scan only
// when a second event has to move into the output register.
`timescale 1ns / 1ps

module timer_pool_scheduler
    import tps_pkg::*;
#(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_item,
    output logic o_stall,
    output logic o_valid,
    output t_out o_item,
    input  logic i_stall
);

    localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_POP   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0]           r_state;
    logic [SW-1:0]        r_idx;
    logic [CW-1:0]        r_cnt;
    logic [TIME_BITS-1:0] r_now;
    t_in                  r_in;
    logic [SW-1:0]        r_rd;
    logic                 r_pend_v;
    t_out                 r_pend;
    logic                 r_out_v;
    t_out                 r_out;
    logic [4:0]           r_ecnt;

    logic [SW-1:0] mem [NUM_TIMERS];

    logic          acc;
    logic          start;
    logic          load;
    logic          adv;
    logic          out_free;
    logic          out_ld;
    t_out          out_d;
    logic          any_fire;
    logic          any_end;
    logic          rep;
    logic          used_hit;
    logic          end_hit;
    logic          rem_ok;
    logic          room;
    logic          we;
    logic [SW-1:0] wa;
    logic [SW-1:0] wd;
    t_cmd          cmd;
    t_out          ev;

    logic [NUM_TIMERS:0]   tok;
    logic [NUM_TIMERS-1:0] used;
    logic [NUM_TIMERS-1:0] endf;
    t_cev                  cev [NUM_TIMERS];

    assign o_stall  = (r_state != ST_IDLE);
    assign acc      = i_valid && !o_stall;
    assign start    = acc && (i_item.func == FUNC_TICK);
    assign out_free = !r_out_v || !i_stall;
    assign room     = (r_cnt < CW'(NUM_TIMERS));

    // Merge the events of the cells and look up the slot to remove
    always_comb begin
        any_fire = 1'b0;
        any_end  = 1'b0;
        used_hit = 1'b0;
        end_hit  = 1'b0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            any_fire = any_fire | cev[i].fire;
            any_end  = any_end | cev[i].ended;
            if (32'(i_item.slot) == i) begin
                used_hit = used[i];
                end_hit  = endf[i];
            end
        end
    end

    assign rem_ok = used_hit;
    assign rep    = (any_fire || any_end) && (r_ecnt < 5'(MAX_RESULTS));
    assign adv    = (r_state == ST_SCAN) && !(rep && r_pend_v && !out_free);
    assign load   = adv || start;

    always_comb begin
        ev.kind       = any_end ? K_ENDED : K_FIRE;
        ev.slot_res   = 4'(r_idx);
        ev.end_notice = any_end;
        ev.last       = 1'b0;
    end

    // Command bus to the cells
    always_comb begin
        cmd.cre        = (r_state == ST_POP);
        cmd.rem        = acc && (i_item.func == FUNC_REMOVE) && rem_ok;
        cmd.sel        = (r_state == ST_POP) ? SEL_W'(r_rd) : SEL_W'(i_item.slot);
        cmd.wait_len   = r_in.wait_ticks;
        cmd.run_len    = r_in.run_ticks;
        cmd.period_len = r_in.period_ticks;
        cmd.flags      = {r_in.has_end, r_in.has_action};
    end

    // Free stack write: fill pass, then pushes of freed slots
    always_comb begin
        we = 1'b0;
        wa = SW'(r_cnt);
        wd = r_idx;
        if (r_state == ST_INIT) begin
            we = 1'b1;
            wa = r_idx;
            wd = SW'(NUM_TIMERS - 1) - r_idx;
        end else if (cmd.rem && room) begin
            we = 1'b1;
            wd = SW'(i_item.slot);
        end else if (adv && any_end && room) begin
            we = 1'b1;
        end
    end

    // Free stack memory, top read registered
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[SW'(r_cnt - CW'(1))];
    end

    // Chain of cells
    assign tok[0] = start;
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        tps_cell #(
            .ID        (g),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (load),
            .i_tok      (tok[g]),
            .i_adv      (adv),
            .i_now      (r_now),
            .i_cmd      (cmd),
            .o_tok      (tok[g+1]),
            .o_ev       (cev[g]),
            .o_used     (used[g]),
            .o_end_flag (endf[g])
        );
    end

    // Output register load: pending event moves out during the scan or at flush
    always_comb begin
        out_ld = 1'b0;
        out_d  = r_pend;
        if (r_state == ST_SCAN) begin
            out_ld = adv && rep && r_pend_v;
        end else if (r_state == ST_FLUSH) begin
            out_ld     = r_pend_v && out_free;
            out_d.last = 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ld) begin
            r_out   <= out_d;
            r_out_v <= 1'b1;
        end else if (r_out_v && !i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    // Controller and pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_idx    <= '0;
            r_cnt    <= CW'(NUM_TIMERS);
            r_now    <= '0;
            r_pend_v <= 1'b0;
            r_ecnt   <= '0;
        end else begin
            case (r_state)
                ST_INIT: begin
                    r_idx <= r_idx + SW'(1);
                    if (r_idx == SW'(NUM_TIMERS - 1)) begin
                        r_idx   <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (acc) begin
                        r_in   <= i_item;
                        r_ecnt <= '0;
                        case (i_item.func)
                            FUNC_TICK: begin
                                r_now   <= r_now + TIME_BITS'(1);
                                r_idx   <= '0;
                                r_state <= ST_SCAN;
                            end
                            FUNC_CREATE: begin
                                if (r_cnt == '0) begin
                                    r_pend   <= '{K_FULL, 4'd0, 1'b0, 1'b0};
                                    r_pend_v <= 1'b1;
                                    r_state  <= ST_FLUSH;
                                end else begin
                                    r_state <= ST_POP;
                                end
                            end
                            FUNC_REMOVE: begin
                                if (rem_ok) begin
                                    if (room) begin
                                        r_cnt <= r_cnt + CW'(1);
                                    end
                                    r_pend <= '{K_REMOVED, i_item.slot,
                                                i_item.notify_end & end_hit, 1'b0};
                                end else begin
                                    r_pend <= '{K_REFUSED, i_item.slot, 1'b0, 1'b0};
                                end
                                r_pend_v <= 1'b1;
                                r_state  <= ST_FLUSH;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_POP: begin
                    r_cnt    <= r_cnt - CW'(1);
                    r_pend   <= '{K_CREATED, 4'(r_rd), 1'b0, 1'b0};
                    r_pend_v <= 1'b1;
                    r_state  <= ST_FLUSH;
                end
                ST_SCAN: begin
                    if (adv) begin
                        if (any_end && room) begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                        if (rep) begin
                            r_ecnt   <= r_ecnt + 5'd1;
                            r_pend   <= ev;
                            r_pend_v <= 1'b1;
                        end
                        r_idx <= r_idx + SW'(1);
                        if (r_idx == SW'(NUM_TIMERS - 1)) begin
                            r_state <= ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

endmodule

/* rtl/tps_chk.sv */
// Port checker for the timer pool scheduler, bound to the top level.
`timescale 1ns / 1ps

module tps_chk
    import tps_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input t_in  i_item,
    input logic o_stall,
    input logic o_valid,
    input t_out o_item,
    input logic i_stall
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // Any known function keeps the block busy in the following cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_item.func == FUNC_TICK ||
        i_item.func == FUNC_CREATE || i_item.func == FUNC_REMOVE) |=> o_stall)
        else $error("block took a second item too early");

    // Pool full reports no slot and no notice
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.kind == K_FULL |-> o_item.slot_res == 4'd0 && !o_item.end_notice)
        else $error("pool full result carries a slot");

    // An ended timer always delivers its notice
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.kind == K_ENDED |-> o_item.end_notice)
        else $error("ended result without notice");

endmodule

bind timer_pool_scheduler tps_chk u_tps_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_item  (i_item),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_item  (o_item),
    .i_stall (i_stall)
);

/* dv/tb.sv */
// Testbench for the timer pool scheduler: random and directed items, scoreboard check.
`timescale 1ns / 1ps

module tb;
    import tps_pkg::*;

    localparam int POOL      = 16;
    localparam int IDLE_LIMIT = 20000;
    // Function code that the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Expected results of the pool, computed from accepted input items
    class pool_scoreboard;
        logic [31:0] now_cnt;
        bit          used[POOL];
        logic [1:0]  ph[POOL];
        logic [31:0] mark[POOL];
        logic [31:0] fired_at[POOL];
        logic [23:0] wlen[POOL];
        logic [23:0] rlen[POOL];
        logic [23:0] plen[POOL];
        logic [1:0]  flg[POOL];
        logic [3:0]  free_slots[POOL];
        int          free_cnt;
        t_out        pending[$];
        int          errors;
        int          n_fire;
        int          n_end;
        int          n_full;

        function new();
            now_cnt = '0;
            for (int i = 0; i < POOL; i++) begin
                used[i] = 0;
                ph[i] = 2'd0;
                free_slots[i] = 4'(POOL - 1 - i);
            end
            free_cnt = POOL;
            errors = 0;
            n_fire = 0;
            n_end = 0;
            n_full = 0;
        endfunction

        function void push_event(ref t_out evs[$], input logic [2:0] k,
                                 input logic [3:0] s, input logic nt);
            t_out e;
            if (evs.size() >= MAX_RESULTS) return;
            e.kind = k;
            e.slot_res = s;
            e.end_notice = nt;
            e.last = 1'b0;
            evs.push_back(e);
        endfunction

        function void free_slot(int s);
            used[s] = 0;
            ph[s] = 2'd0;
            if (free_cnt < POOL) begin
                free_slots[free_cnt] = 4'(s);
                free_cnt++;
            end
        endfunction

        function void note_input(t_in it);
            t_out evs[$];
            int s;
            logic nt;
            if (it.func == FUNC_TICK) begin
                now_cnt = now_cnt + 1;
                for (int i = 0; i < POOL; i++) begin
                    if (!used[i]) continue;
                    if (ph[i] == 2'd0) begin
                        mark[i] = now_cnt;
                        ph[i] = 2'd1;
                    end else if (ph[i] == 2'd1) begin
                        if (wlen[i] == 0 || (now_cnt - mark[i]) >= {8'd0, wlen[i]}) begin
                            ph[i] = 2'd2;
                            mark[i] = now_cnt;
                            fired_at[i] = now_cnt;
                        end
                    end else if (rlen[i] == 0 || (now_cnt - mark[i]) <= {8'd0, rlen[i]}) begin
                        if (flg[i][0]) begin
                            if (plen[i] == 0) begin
                                push_event(evs, K_FIRE, 4'(i), 1'b0);
                            end else if ((now_cnt - fired_at[i]) >= {8'd0, plen[i]}) begin
                                fired_at[i] = now_cnt;
                                push_event(evs, K_FIRE, 4'(i), 1'b0);
                            end
                        end
                    end else if (flg[i][1]) begin
                        push_event(evs, K_ENDED, 4'(i), 1'b1);
                        free_slot(i);
                    end
                end
            end else if (it.func == FUNC_CREATE) begin
                if (free_cnt == 0) begin
                    push_event(evs, K_FULL, 4'd0, 1'b0);
                end else begin
                    free_cnt--;
                    s = free_slots[free_cnt];
                    used[s] = 1;
                    ph[s] = 2'd0;
                    wlen[s] = it.wait_ticks;
                    rlen[s] = it.run_ticks;
                    plen[s] = it.period_ticks;
                    flg[s] = {it.has_end, it.has_action};
                    push_event(evs, K_CREATED, 4'(s), 1'b0);
                end
            end else if (it.func == FUNC_REMOVE) begin
                s = it.slot;
                if (!used[s]) begin
                    push_event(evs, K_REFUSED, 4'(s), 1'b0);
                end else begin
                    nt = it.notify_end & flg[s][1];
                    free_slot(s);
                    push_event(evs, K_REMOVED, 4'(s), nt);
                end
            end
            if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
            foreach (evs[j]) pending.push_back(evs[j]);
        endfunction

        function void check_result(t_out got);
            t_out exp;
            if (pending.size() == 0) begin
                $error("unexpected result kind=%0d slot=%0d", got.kind, got.slot_res);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.kind == K_FIRE) n_fire++;
            if (got.kind == K_ENDED) n_end++;
            if (got.kind == K_FULL) n_full++;
            if (got.kind !== exp.kind) begin
                $error("kind: expected %0d, got %0d", exp.kind, got.kind);
                errors++;
            end
            if (got.slot_res !== exp.slot_res) begin
                $error("slot_res: expected %0d, got %0d", exp.slot_res, got.slot_res);
                errors++;
            end
            if (got.end_notice !== exp.end_notice) begin
                $error("end_notice: expected %0d, got %0d", exp.end_notice, got.end_notice);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, got %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    t_in  i_item;
    logic o_stall;
    logic o_valid;
    t_out o_item;
    logic i_stall;

    pool_scoreboard sb;
    int  idle_cycles;
    int  n_items;

    timer_pool_scheduler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_item(i_item), .o_stall(o_stall),
        .o_valid(o_valid), .o_item(o_item), .i_stall(i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one item and wait until the block takes it
    task automatic send_item(t_in it);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(it);
        n_items++;
    endtask

    function automatic t_in make_create(logic [23:0] w, logic [23:0] r, logic [23:0] p,
                                        logic act, logic en);
        t_in it;
        it = t_in'($urandom());
        it.func = FUNC_CREATE;
        it.wait_ticks = w;
        it.run_ticks = r;
        it.period_ticks = p;
        it.has_action = act;
        it.has_end = en;
        return it;
    endfunction

    function automatic t_in make_op(logic [1:0] f, logic [3:0] s, logic nt);
        t_in it;
        it = t_in'({$urandom(), $urandom(), $urandom()});
        it.func = f;
        it.slot = s;
        it.notify_end = nt;
        return it;
    endfunction

    function automatic logic [23:0] rand_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 24'd0;
        if (r < 8) return 24'($urandom_range(1, 6));
        if (r < 9) return 24'hFFFFFF;
        return 24'($urandom());
    endfunction

    // Receiver: random stall, check each accepted result
    initial begin
        int g;
        i_stall = 1'b1;
        wait (i_rst_n);
        forever begin
            g = gap_len();
            if (g != 0) begin
                i_stall <= 1'b1;
                repeat (g) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            if (o_valid) sb.check_result(o_item);
            while (o_valid && $urandom_range(0, 3) != 0) begin
                @(posedge i_clk);
                if (o_valid) sb.check_result(o_item);
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int r;
        int ticks;
        sb = new();
        n_items = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every operation, refused remove, idle end
        send_item(make_op(FUNC_REMOVE, 4'd0, 1'b1));
        send_item(make_op(FUNC_UNUSED, 4'd15, 1'b1));
        send_item(make_create(24'd0, 24'd0, 24'd0, 1'b1, 1'b1));
        send_item(make_create(24'd1, 24'd2, 24'd1, 1'b1, 1'b1));
        send_item(make_create(24'd0, 24'd1, 24'd0, 1'b0, 1'b0));
        send_item(make_create(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0));
        repeat (6) send_item(make_op(FUNC_TICK, 4'($urandom()), 1'($urandom())));
        send_item(make_op(FUNC_REMOVE, 4'd3, 1'b1));
        send_item(make_op(FUNC_REMOVE, 4'd0, 1'b1));
        send_item(make_op(FUNC_REMOVE, 4'd15, 1'b0));
        // Fill the pool, then overflow it
        for (int i = 0; i < 17; i++)
            send_item(make_create(24'd0, 24'd3, 24'd0, 1'($urandom()), 1'b1));
        repeat (5) send_item(make_op(FUNC_TICK, 4'd0, 1'b0));

        // Random: mostly ticks and creates, some removes and noise
        for (int i = 0; i < 133; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(make_op(FUNC_TICK, 4'($urandom()), 1'($urandom())));
            else if (r < 75)
                send_item(make_create(rand_len(), rand_len(), rand_len(),
                                      1'($urandom()), 1'($urandom())));
            else if (r < 95)
                send_item(make_op(FUNC_REMOVE, 4'($urandom()), 1'($urandom())));
            else
                send_item(make_op(FUNC_UNUSED, 4'($urandom()), 1'($urandom())));
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4 * POOL + 10) @(posedge i_clk);
        $display("tb: %0d items sent; %0d fires, %0d ends, %0d pool-full results seen",
                 n_items, sb.n_fire, sb.n_end, sb.n_full);
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tps_pkg.sv
rtl/tps_cell.sv
rtl/timer_pool_scheduler.sv
rtl/tps_chk.sv
dv/tb.sv
